// ===== hdl/aeq_pkg.sv =====
// ----------------------------------------------------------------------------
// aeq_pkg
// Shared constants for the alarm expiry queue.
// ----------------------------------------------------------------------------
package aeq_pkg;

    localparam int SLOTS_DEF  = 32;
    localparam int QUEUES_DEF = 5;
    localparam int TW         = 63;
    localparam int IDW        = 5;
    localparam int QW         = 3;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_FIRE   = 2'd2;

    localparam logic [1:0] RK_START  = 2'd0;
    localparam logic [1:0] RK_CANCEL = 2'd1;
    localparam logic [1:0] RK_FIRED  = 2'd2;
    localparam logic [1:0] RK_DONE   = 2'd3;

endpackage

// ===== hdl/aeq_slot_mem.sv =====
// ----------------------------------------------------------------------------
// aeq_slot_mem
// Per-slot storage: expiry times, queue index and link. One synchronous
// write port and one synchronous read port with registered read data.
// A full write stores every field; a link write stores the link alone.
// ----------------------------------------------------------------------------
module aeq_slot_mem #(
    parameter int SLOTS = aeq_pkg::SLOTS_DEF,
    parameter int SW    = 6
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic                  link_we,
    input  logic [SW-1:0]         waddr,
    input  logic [aeq_pkg::TW-1:0] wsoft,
    input  logic [aeq_pkg::TW-1:0] whard,
    input  logic [aeq_pkg::QW-1:0] wqueue,
    input  logic [SW-1:0]         wlink,
    input  logic [SW-1:0]         raddr,
    output logic [aeq_pkg::TW-1:0] rsoft,
    output logic [aeq_pkg::TW-1:0] rhard,
    output logic [aeq_pkg::QW-1:0] rqueue,
    output logic [SW-1:0]         rlink
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [aeq_pkg::TW-1:0] soft_mem [SLOTS];
    logic [aeq_pkg::TW-1:0] hard_mem [SLOTS];
    logic [aeq_pkg::QW-1:0] queue_mem [SLOTS];
    logic [SW-1:0]          link_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            soft_mem[waddr[AW-1:0]]  <= wsoft;
            hard_mem[waddr[AW-1:0]]  <= whard;
            queue_mem[waddr[AW-1:0]] <= wqueue;
        end
        if (we || link_we)
        begin
            link_mem[waddr[AW-1:0]]  <= wlink;
        end
        rsoft  <= soft_mem[raddr[AW-1:0]];
        rhard  <= hard_mem[raddr[AW-1:0]];
        rqueue <= queue_mem[raddr[AW-1:0]];
        rlink  <= link_mem[raddr[AW-1:0]];
    end
endmodule

// ===== hdl/alarm_expiry_queue_top.sv =====
// ----------------------------------------------------------------------------
// alarm_expiry_queue_top
// Alarm slots held in per-type linked lists ordered by hard expiry.
// ----------------------------------------------------------------------------
// channel   direction  handshake        payload
// command   in         start / busy     cmd, alarm_id, alarm_type, times
// result    out        strobe (1 cycle) result_kind .. last
//
// Each list step is a read state and a check state on the single read port of the slot memory.
// Start: unlinks the slot from its old list, then walks the target list and inserts
// it by hard expiry. Cancel: unlinks the slot, walking its list to the predecessor.
// Fire: pops due alarms from the head of the list, one fired result per popped alarm.
// Out-of-range start, cancel of an idle slot: result next cycle, busy stays low.
// Reset clears the queued flags and list heads; slot storage is not cleared.
// The receiver cannot stall; busy stays high until the last result is out.
module alarm_expiry_queue_top #(
    parameter int SLOTS  = aeq_pkg::SLOTS_DEF,
    parameter int QUEUES = aeq_pkg::QUEUES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              cmd,
    input  logic [aeq_pkg::IDW-1:0] alarm_id,
    input  logic [aeq_pkg::QW-1:0]  alarm_type,
    input  logic [aeq_pkg::TW-1:0]  soft_expiry,
    input  logic [aeq_pkg::TW-1:0]  hard_expiry,
    input  logic [aeq_pkg::TW-1:0]  now_time,
    output logic                    strobe,
    output logic [1:0]              result_kind,
    output logic [aeq_pkg::IDW-1:0] fired_slot,
    output logic                    was_active,
    output logic                    head_valid,
    output logic [aeq_pkg::TW-1:0]  head_deadline,
    output logic [aeq_pkg::TW-1:0]  head_soft,
    output logic                    last
);
    localparam int SW = 6;
    localparam logic [SW-1:0] NIL = '1;
    localparam int QI = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int SI = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] SLOT_LIM = SW'(SLOTS);
    localparam logic [SW:0]   STEP_LIM = {1'b0, SLOT_LIM};

    typedef enum logic [3:0] {
        S_IDLE, S_UL_RD, S_UL_GET, S_UW_RD, S_UW_CHK,
        S_IN_SET, S_IN_RD, S_IN_CHK, S_IN_WR, S_IN_LNK,
        S_HD_SEL, S_RD, S_CHK
    } state_t;

    state_t                 state_reg;
    logic [1:0]             cmd_reg;
    logic [SW-1:0]          id_reg;
    logic [aeq_pkg::QW-1:0] q_reg, oq_reg;
    logic [aeq_pkg::TW-1:0] soft_reg, hard_reg, now_reg;
    logic [SW-1:0]          cur_reg, prev_reg, slink_reg;
    logic [SW:0]            steps_reg;
    logic                   act_reg;
    logic [SW-1:0]          head_reg [QUEUES];
    logic [SLOTS-1:0]       queued_reg;

    logic                   we, link_we;
    logic [SW-1:0]          waddr, wlink, raddr;
    logic [aeq_pkg::TW-1:0] rsoft, rhard;
    logic [aeq_pkg::QW-1:0] rqueue;
    logic [SW-1:0]          rlink;

    logic                   id_ok, q_ok, cur_ok, walk_end;
    state_t                 after_unlink;

    aeq_slot_mem #(.SLOTS(SLOTS), .SW(SW)) u_mem (
        .clk(clk), .we(we), .link_we(link_we), .waddr(waddr), .wsoft(soft_reg),
        .whard(hard_reg), .wqueue(q_reg), .wlink(wlink), .raddr(raddr),
        .rsoft(rsoft), .rhard(rhard), .rqueue(rqueue), .rlink(rlink)
    );

    assign id_ok        = ({1'b0, alarm_id} < SLOT_LIM);
    assign q_ok         = ({1'b0, alarm_type} < 4'(QUEUES));
    assign cur_ok       = (cur_reg < SLOT_LIM);
    assign walk_end     = !cur_ok || (steps_reg >= STEP_LIM);
    assign after_unlink = (cmd_reg == aeq_pkg::CMD_START) ? S_IN_SET : S_HD_SEL;

    always_comb
    begin
        we      = 1'b0;
        link_we = 1'b0;
        waddr   = id_reg;
        wlink   = cur_reg;
        raddr   = cur_reg;
        unique case (state_reg)
            S_UL_RD:  raddr = id_reg;
            S_UW_CHK:
            begin
                // predecessor found: bypass the removed slot
                link_we = (rlink == id_reg);
                waddr   = cur_reg;
                wlink   = slink_reg;
            end
            S_IN_WR:
            begin
                we    = 1'b1;
                waddr = id_reg;
                wlink = cur_ok ? cur_reg : NIL;
            end
            S_IN_LNK:
            begin
                link_we = (prev_reg != NIL);
                waddr   = prev_reg;
                wlink   = id_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            queued_reg <= '0;
            for (int i = 0; i < QUEUES; i++)
            begin
                head_reg[i] <= NIL;
            end
            cmd_reg       <= '0;
            id_reg        <= '0;
            q_reg         <= '0;
            oq_reg        <= '0;
            soft_reg      <= '0;
            hard_reg      <= '0;
            now_reg       <= '0;
            cur_reg       <= NIL;
            prev_reg      <= NIL;
            slink_reg     <= NIL;
            steps_reg     <= '0;
            act_reg       <= 1'b0;
            strobe        <= 1'b0;
            last          <= 1'b0;
            result_kind   <= '0;
            fired_slot    <= '0;
            was_active    <= 1'b0;
            head_valid    <= 1'b0;
            head_deadline <= '0;
            head_soft     <= '0;
        end
        else
        begin
            strobe <= 1'b0;
            last   <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd;
                        id_reg    <= {1'b0, alarm_id};
                        q_reg     <= alarm_type;
                        soft_reg  <= soft_expiry;
                        hard_reg  <= hard_expiry;
                        now_reg   <= now_time;
                        act_reg   <= 1'b0;
                        prev_reg  <= NIL;
                        steps_reg <= '0;
                        if (cmd == aeq_pkg::CMD_FIRE)
                        begin
                            cur_reg   <= q_ok ? head_reg[alarm_type[QI-1:0]] : NIL;
                            state_reg <= S_RD;
                        end
                        else if (cmd == aeq_pkg::CMD_START && id_ok && q_ok)
                        begin
                            state_reg <= S_UL_RD;
                        end
                        else if (cmd == aeq_pkg::CMD_CANCEL && id_ok
                                 && queued_reg[alarm_id[SI-1:0]])
                        begin
                            act_reg   <= 1'b1;
                            state_reg <= S_UL_RD;
                        end
                        else if (cmd == aeq_pkg::CMD_START
                                 || cmd == aeq_pkg::CMD_CANCEL)
                        begin
                            strobe        <= 1'b1;
                            last          <= 1'b1;
                            result_kind   <= (cmd == aeq_pkg::CMD_START)
                                             ? aeq_pkg::RK_START : aeq_pkg::RK_CANCEL;
                            fired_slot    <= alarm_id;
                            was_active    <= 1'b0;
                            head_valid    <= 1'b0;
                            head_deadline <= '0;
                            head_soft     <= '0;
                        end
                    end
                end
                // read the slot itself to learn its queue and successor
                S_UL_RD: state_reg <= S_UL_GET;
                S_UL_GET:
                begin
                    oq_reg    <= rqueue;
                    slink_reg <= rlink;
                    steps_reg <= '0;
                    if (!queued_reg[id_reg[SI-1:0]])
                    begin
                        state_reg <= after_unlink;
                    end
                    else
                    begin
                        queued_reg[id_reg[SI-1:0]] <= 1'b0;
                        if (head_reg[rqueue[QI-1:0]] == id_reg)
                        begin
                            head_reg[rqueue[QI-1:0]] <= rlink;
                            state_reg <= after_unlink;
                        end
                        else
                        begin
                            cur_reg   <= head_reg[rqueue[QI-1:0]];
                            state_reg <= S_UW_RD;
                        end
                    end
                end
                S_UW_RD: state_reg <= walk_end ? after_unlink : S_UW_CHK;
                S_UW_CHK:
                begin
                    if (rlink == id_reg)
                    begin
                        state_reg <= after_unlink;
                    end
                    else
                    begin
                        cur_reg   <= rlink;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_UW_RD;
                    end
                end
                // insertion walk begins at the target head
                S_IN_SET:
                begin
                    cur_reg   <= head_reg[q_reg[QI-1:0]];
                    prev_reg  <= NIL;
                    steps_reg <= '0;
                    state_reg <= S_IN_RD;
                end
                S_IN_RD: state_reg <= walk_end ? S_IN_WR : S_IN_CHK;
                S_IN_CHK:
                begin
                    if (rhard <= hard_reg)
                    begin
                        prev_reg  <= cur_reg;
                        cur_reg   <= rlink;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_IN_RD;
                    end
                    else
                    begin
                        state_reg <= S_IN_WR;
                    end
                end
                S_IN_WR:
                begin
                    queued_reg[id_reg[SI-1:0]] <= 1'b1;
                    if (prev_reg == NIL)
                    begin
                        head_reg[q_reg[QI-1:0]] <= id_reg;
                    end
                    state_reg <= S_IN_LNK;
                end
                S_IN_LNK: state_reg <= S_HD_SEL;
                S_HD_SEL:
                begin
                    if (cmd_reg == aeq_pkg::CMD_START)
                    begin
                        cur_reg <= head_reg[q_reg[QI-1:0]];
                    end
                    else
                    begin
                        cur_reg <= head_reg[oq_reg[QI-1:0]];
                    end
                    state_reg <= S_RD;
                end
                S_RD: state_reg <= S_CHK;
                S_CHK:
                begin
                    strobe <= 1'b1;
                    if (cmd_reg == aeq_pkg::CMD_FIRE && cur_ok && rsoft <= now_reg)
                    begin
                        result_kind   <= aeq_pkg::RK_FIRED;
                        fired_slot    <= cur_reg[aeq_pkg::IDW-1:0];
                        was_active    <= 1'b0;
                        head_valid    <= 1'b1;
                        head_deadline <= rhard;
                        head_soft     <= rsoft;
                        head_reg[q_reg[QI-1:0]]     <= rlink;
                        queued_reg[cur_reg[SI-1:0]] <= 1'b0;
                        cur_reg   <= rlink;
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        last <= 1'b1;
                        if (cmd_reg == aeq_pkg::CMD_FIRE)
                        begin
                            result_kind <= aeq_pkg::RK_DONE;
                            fired_slot  <= '0;
                        end
                        else
                        begin
                            result_kind <= (cmd_reg == aeq_pkg::CMD_START)
                                           ? aeq_pkg::RK_START : aeq_pkg::RK_CANCEL;
                            fired_slot  <= id_reg[aeq_pkg::IDW-1:0];
                        end
                        was_active    <= act_reg;
                        head_valid    <= cur_ok;
                        head_deadline <= cur_ok ? rhard : '0;
                        head_soft     <= cur_ok ? rsoft : '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe) else $error("last without strobe");
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> !busy) else $error("busy after last result");
    a_no_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result_kind == aeq_pkg::RK_FIRED) |-> !last)
        else $error("fired result marked last");
    a_only_fired_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> result_kind == aeq_pkg::RK_FIRED)
        else $error("non-fired result not last");
    a_fired_head: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result_kind == aeq_pkg::RK_FIRED) |-> head_valid)
        else $error("fired result without head");
endmodule

// ===== verif/alarm_expiry_queue_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_expiry_queue_top_tb
// Drives start, cancel, fire and unused-code transactions at the alarm expiry queue and
// checks every result against a behavioral model of the per-type lists.
// ----------------------------------------------------------------------------
module alarm_expiry_queue_top_tb;

    localparam int NSLOT = aeq_pkg::SLOTS_DEF;
    localparam int NQ    = aeq_pkg::QUEUES_DEF;
    localparam int TW    = aeq_pkg::TW;
    localparam int IDW   = aeq_pkg::IDW;
    localparam int QW    = aeq_pkg::QW;

    typedef struct packed {
        logic [1:0]    kind;
        logic [IDW-1:0] slot;
        logic          act;
        logic          hv;
        logic [TW-1:0] hd;
        logic [TW-1:0] hs;
        logic          lst;
    } alarm_res_t;

    class alarm_board;
        logic [TW-1:0] soft_t [NSLOT];
        logic [TW-1:0] hard_t [NSLOT];
        bit            queued [NSLOT];
        int            owner  [NSLOT];
        int            lists  [NQ][$];
        alarm_res_t    pending[$];
        int            fired_cnt;
        int            errors;

        function void clear();
            foreach (queued[i]) queued[i] = 0;
            foreach (lists[i]) lists[i].delete();
            pending.delete();
            fired_cnt = 0;
            errors = 0;
        endfunction

        task report_mismatch(input string what, input logic [TW-1:0] got,
                             input logic [TW-1:0] want);
            errors++;
            $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
        endtask

        function alarm_res_t head_res(input logic [1:0] k, input int s,
                                      input bit a, input int q);
            alarm_res_t r;
            r = '0;
            r.kind = k; r.slot = IDW'(s); r.act = a; r.lst = 1;
            if (q < NQ && lists[q].size() > 0) begin
                r.hv = 1;
                r.hd = hard_t[lists[q][0]];
                r.hs = soft_t[lists[q][0]];
            end
            return r;
        endfunction

        function void unlink(input int s);
            int q;
            if (!queued[s]) return;
            queued[s] = 0;
            q = owner[s];
            for (int i = 0; i < lists[q].size(); i++)
                if (lists[q][i] == s)
                begin
                    lists[q].delete(i);
                    break;
                end
        endfunction

        function void note_cmd(input logic [1:0] c, input int id, input int q,
                               input logic [TW-1:0] sft, input logic [TW-1:0] hrd,
                               input logic [TW-1:0] now);
            alarm_res_t r;
            int pos;
            if (c == aeq_pkg::CMD_START) begin
                if (id >= NSLOT || q >= NQ) begin
                    r = '0; r.kind = aeq_pkg::RK_START; r.slot = IDW'(id); r.lst = 1;
                    pending.push_back(r);
                    return;
                end
                unlink(id);
                soft_t[id] = sft; hard_t[id] = hrd;
                pos = 0;
                while (pos < lists[q].size() && hard_t[lists[q][pos]] <= hrd) pos++;
                lists[q].insert(pos, id);
                owner[id] = q; queued[id] = 1;
                pending.push_back(head_res(aeq_pkg::RK_START, id, 0, q));
            end else if (c == aeq_pkg::CMD_CANCEL) begin
                if (id >= NSLOT || !queued[id]) begin
                    r = '0; r.kind = aeq_pkg::RK_CANCEL; r.slot = IDW'(id); r.lst = 1;
                    pending.push_back(r);
                    return;
                end
                pos = owner[id];
                unlink(id);
                pending.push_back(head_res(aeq_pkg::RK_CANCEL, id, 1, pos));
            end else if (c == aeq_pkg::CMD_FIRE) begin
                if (q < NQ)
                    while (lists[q].size() > 0 && soft_t[lists[q][0]] <= now) begin
                        pos = lists[q].pop_front();
                        queued[pos] = 0;
                        r = '0; r.kind = aeq_pkg::RK_FIRED; r.slot = IDW'(pos); r.hv = 1;
                        r.hd = hard_t[pos]; r.hs = soft_t[pos];
                        pending.push_back(r);
                        fired_cnt++;
                    end
                pending.push_back(head_res(aeq_pkg::RK_DONE, 0, 0, q));
            end
        endfunction

        task check_result(input alarm_res_t got);
            alarm_res_t w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result kind", TW'(got.kind), '0);
                return;
            end
            w = pending.pop_front();
            if (got.kind != w.kind)
                report_mismatch("result_kind", TW'(got.kind), TW'(w.kind));
            if (got.slot != w.slot)
                report_mismatch("fired_slot", TW'(got.slot), TW'(w.slot));
            if (got.act != w.act)
                report_mismatch("was_active", TW'(got.act), TW'(w.act));
            if (got.hv != w.hv)
                report_mismatch("head_valid", TW'(got.hv), TW'(w.hv));
            if (got.hd != w.hd)     report_mismatch("head_deadline", got.hd, w.hd);
            if (got.hs != w.hs)     report_mismatch("head_soft", got.hs, w.hs);
            if (got.lst != w.lst)
                report_mismatch("last", TW'(got.lst), TW'(w.lst));
        endtask
    endclass

    logic clk = 0, rst_n = 0, start = 0;
    logic [1:0] cmd = '0;
    logic [IDW-1:0] alarm_id = '0;
    logic [QW-1:0] alarm_type = '0;
    logic [TW-1:0] soft_expiry = '0, hard_expiry = '0, now_time = '0;
    logic busy, strobe, was_active, head_valid, last;
    logic [1:0] result_kind;
    logic [IDW-1:0] fired_slot;
    logic [TW-1:0] head_deadline, head_soft;

    alarm_board board = new();
    int idle_pct = 0;
    int cmd_total = 0;

    alarm_expiry_queue_top uut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
        if (rst_n && strobe)
            board.check_result({result_kind, fired_slot, was_active, head_valid,
                                head_deadline, head_soft, last});

    function automatic logic [TW-1:0] rand_time();
        return TW'({$urandom, $urandom});
    endfunction

    // start stays high after acceptance; the next issue or drain replaces it
    task automatic issue(input logic [1:0] c, input int id, input int q,
                         input logic [TW-1:0] sft, input logic [TW-1:0] hrd,
                         input logic [TW-1:0] now);
        logic [IDW-1:0] idv;
        logic [QW-1:0]  qv;
        idv = IDW'(id);
        qv  = QW'(q);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1; cmd <= c; alarm_id <= idv; alarm_type <= qv;
        soft_expiry <= sft; hard_expiry <= hrd; now_time <= now;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_cmd(c, int'(idv), int'(qv), sft, hrd, now);
        cmd_total++;
    endtask

    task automatic drain();
        start <= 0;
        while (board.pending.size() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic random_cmd(input logic [TW-1:0] base);
        int r, q;
        logic [TW-1:0] s, h;
        r = $urandom_range(99, 0);
        q = ($urandom_range(9, 0) == 0) ? $urandom_range(7, 5) : $urandom_range(NQ - 1, 0);
        s = base + $urandom_range(400, 0);
        h = ($urandom_range(3, 0) == 0) ? s : s + $urandom_range(50, 0);
        if ($urandom_range(19, 0) == 0) begin
            s = rand_time(); h = rand_time();
        end
        if (r < 50)
            issue(aeq_pkg::CMD_START, $urandom_range(NSLOT - 1, 0), q, s, h, 0);
        else if (r < 70)
            issue(aeq_pkg::CMD_CANCEL, $urandom_range(NSLOT - 1, 0), 0, rand_time(),
                  rand_time(), 0);
        else if (r < 97)
            issue(aeq_pkg::CMD_FIRE, $urandom, q, rand_time(), rand_time(),
                  base + $urandom_range(300, 0));
        else
            issue(2'd3, $urandom, $urandom, rand_time(), rand_time(), rand_time());
    endtask

    localparam logic [TW-1:0] TMAX = '1;

    initial
    begin
        logic [TW-1:0] base;
        board.clear();
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        issue(aeq_pkg::CMD_CANCEL, 3, 0, 0, 0, 0);
        issue(aeq_pkg::CMD_FIRE, 0, 0, 0, 0, TMAX);
        issue(aeq_pkg::CMD_START, 0, 0, 100, 200, 0);
        issue(aeq_pkg::CMD_START, 1, 0, 50, 200, 0);
        issue(aeq_pkg::CMD_START, 2, 0, 10, 100, 0);
        issue(aeq_pkg::CMD_START, 31, 4, TMAX, TMAX, 0);
        issue(aeq_pkg::CMD_START, 5, 7, 1, 1, 0);
        issue(aeq_pkg::CMD_START, 0, 1, 0, 0, 0);
        issue(aeq_pkg::CMD_FIRE, 0, 0, 0, 0, 49);
        issue(aeq_pkg::CMD_FIRE, 0, 0, 0, 0, 50);
        issue(aeq_pkg::CMD_CANCEL, 1, 0, 0, 0, 0);
        issue(aeq_pkg::CMD_CANCEL, 1, 0, 0, 0, 0);
        issue(aeq_pkg::CMD_FIRE, 0, 5, 0, 0, TMAX);
        issue(aeq_pkg::CMD_FIRE, 0, 4, 0, 0, TMAX);
        issue(aeq_pkg::CMD_FIRE, 0, 1, 0, 0, 0);
        issue(2'd3, 31, 7, TMAX, TMAX, TMAX);
        for (int i = 0; i < 6; i++) issue(aeq_pkg::CMD_START, i + 8, 2, 0, 5, 0);
        issue(aeq_pkg::CMD_FIRE, 0, 2, 0, 0, 0);
        drain();

        base = 0;
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 51 : (ph == 2) ? 29 : 0;
            for (int i = 0; i < 32; i++) begin
                random_cmd(base);
                base += $urandom_range(10, 0);
            end
            for (int q = 0; q < NQ; q++) issue(aeq_pkg::CMD_FIRE, 0, q, 0, 0, TMAX);
            drain();
        end
        $display("tb: %0d commands issued, %0d alarms fired and checked",
                 cmd_total, board.fired_cnt);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/aeq_pkg.sv
hdl/aeq_slot_mem.sv
hdl/alarm_expiry_queue_top.sv
verif/alarm_expiry_queue_top_tb.sv
